// File: rtl/prse_pkg.sv
// Shared types, widths and constants of the pulse rate and SpO2 estimator.
package prse_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int DIVISOR_W    = 8;
    localparam int LIMIT_W      = 16;
    localparam int CFG_DATA_W   = 32;
    localparam int APB_ADDR_W   = 3;

    localparam int RATE_W       = 11;
    localparam int INTERVAL_W   = 21;
    localparam int TOTAL_W      = 16;
    localparam int OXY_W        = 7;
    localparam int POS_W        = 11;
    localparam int SINCE_W      = 16;

    localparam int S_TDATA_W    = 48;
    localparam int M_TDATA_W    = 56;

    // Shared divider: the widest dividend is 2047 beats times RATE_SCALE.
    localparam int DIV_NUM_W    = 24;
    localparam int DIV_DEN_W    = 16;

    localparam int OXY_NUM_W    = 21;
    localparam int RATE_NUM_W   = 23;
    localparam int RATE_MUL_W   = 15;

    localparam int WINDOW_LENGTH_DEF = 1500;

    localparam logic [DIVISOR_W-1:0] DIVISOR_RST = 8'd2;
    localparam logic [LIMIT_W-1:0]   LIMIT_RST   = 16'd255;

    // Register index, taken from address bit 2.
    localparam logic REG_DIVISOR = 1'b0;
    localparam logic REG_LIMIT   = 1'b1;

    localparam logic [POS_W-1:0] POS_QUARTER = 11'd250;
    localparam logic [POS_W-1:0] POS_THIRD   = 11'd500;
    localparam logic [POS_W-1:0] POS_TWO_THIRDS = 11'd1000;

    localparam int MUL_QUARTER     = 12;
    localparam int MUL_THIRD       = 6;
    localparam int MUL_TWO_THIRDS  = 3;
    // Beats per minute times samples per window: 60 s at 50 samples per second.
    localparam int RATE_SCALE      = 3000;
    localparam int MS_PER_SAMPLE   = 20;
    localparam int OXY_SCALE       = 25;
    localparam int OXY_BASE        = 105;
    localparam int OXY_MAX         = 99;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } prse_state_t;

    typedef enum logic [1:0] {
        OP_THRESHOLD,
        OP_OXYGEN,
        OP_RATE
    } prse_op_t;

    function automatic logic [RATE_W-1:0] sat_rate(input logic [DIV_NUM_W-1:0] v);
        logic [RATE_W-1:0] r;
        if (v > DIV_NUM_W'({RATE_W{1'b1}})) begin
            r = '1;
        end else begin
            r = v[RATE_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/pulse_rate_spo2_estimator.sv
// Top level of the pulse rate and SpO2 estimator: stream ports, registers and sequencer.
//
// One 50 Hz sample is taken per input word and exactly one result word is returned for it.
// The sample is evaluated in the EVAL state; the divisions it needs (peak over threshold
// divisor on a new peak, the SpO2 ratio on a new peak with nonzero IR, and the window
// rate at the end of the window) then run one after another on a single shared
// restoring divider that gives one quotient bit per cycle. From 0 to 3 divisions run
// per word, and s_tready stays low from acceptance until the result word is handed
// over. A finished result waits in the output register while the next sample is
// accepted. The threshold divisor lies at byte address 0 and the beat count limit at
// address 4; write them only while idle.
module pulse_rate_spo2_estimator #(
    parameter int WINDOW_LENGTH = prse_pkg::WINDOW_LENGTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // APB configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [prse_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [prse_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [prse_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    // Sample stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // ir_level [15:0], red_smooth [31:16], ir_smooth [47:32]
    input  logic [prse_pkg::S_TDATA_W-1:0]  s_tdata,
    // sample_valid [0]
    input  logic                            s_tuser,
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // heart_rate_bpm [10:0], beat_interval_ms [31:11], beat_total [47:32],
    // oxygen_percent [54:48], zero [55]
    output logic [prse_pkg::M_TDATA_W-1:0]  m_tdata,
    // beat_seen [0]
    output logic                            m_tuser
);
    import prse_pkg::*;

    prse_state_t state_reg, state_next;

    logic [DIVISOR_W-1:0]  divisor_cfg_reg;
    logic [LIMIT_W-1:0]    limit_cfg_reg;
    logic                  cfg_we;

    logic                  valid_in_reg, valid_in_next;
    logic [SAMPLE_W-1:0]   ir_reg, ir_next;
    logic [SAMPLE_W-1:0]   red_reg, red_next;
    logic [SAMPLE_W-1:0]   irs_reg, irs_next;

    logic [SAMPLE_W-1:0]   peak_reg, peak_next;
    logic [SAMPLE_W-1:0]   thr_reg, thr_next;
    logic [RATE_W-1:0]     wbeats_reg, wbeats_next;
    logic [POS_W-1:0]      wpos_reg, wpos_next;
    logic [SINCE_W-1:0]    since_reg, since_next;
    logic [TOTAL_W-1:0]    total_reg, total_next;
    logic [RATE_W-1:0]     rate_reg, rate_next;
    logic [INTERVAL_W-1:0] interval_reg, interval_next;
    logic [OXY_W-1:0]      oxy_reg, oxy_next;
    logic                  beat_reg, beat_next;

    logic                  need_thr_reg, need_thr_next;
    logic                  need_oxy_reg, need_oxy_next;
    logic                  need_rate_reg, need_rate_next;
    logic [RATE_NUM_W-1:0] rate_num_reg, rate_num_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic                  m_tuser_reg, m_tuser_next;

    prse_op_t              cur_op;
    logic                  div_start;
    logic [DIV_NUM_W-1:0]  div_dividend;
    logic [DIV_DEN_W-1:0]  div_divisor;
    logic                  div_done;
    logic [DIV_NUM_W-1:0]  div_quotient;
    logic [OXY_NUM_W-1:0]  oxy_num;

    // Configuration registers
    assign cfg_we = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LIMIT) ? CFG_DATA_W'(limit_cfg_reg)
                                            : CFG_DATA_W'(divisor_cfg_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divisor_cfg_reg <= DIVISOR_RST;
            limit_cfg_reg   <= LIMIT_RST;
        end else if (cfg_we) begin
            if (paddr[2] == REG_LIMIT) begin
                limit_cfg_reg <= pwdata[LIMIT_W-1:0];
            end else begin
                divisor_cfg_reg <= pwdata[DIVISOR_W-1:0];
            end
        end
    end

    // Divider operand selection; the threshold goes first, then SpO2, then the rate.
    assign oxy_num = OXY_NUM_W'(red_reg) * OXY_NUM_W'(OXY_SCALE)
                   + OXY_NUM_W'(irs_reg) - OXY_NUM_W'(1);

    always_comb begin
        if (need_thr_reg) begin
            cur_op = OP_THRESHOLD;
        end else if (need_oxy_reg) begin
            cur_op = OP_OXYGEN;
        end else begin
            cur_op = OP_RATE;
        end
        case (cur_op)
            OP_THRESHOLD: begin
                div_dividend = DIV_NUM_W'(ir_reg);
                div_divisor  = (divisor_cfg_reg == '0) ? DIV_DEN_W'(1)
                                                       : DIV_DEN_W'(divisor_cfg_reg);
            end
            OP_OXYGEN: begin
                div_dividend = DIV_NUM_W'(oxy_num);
                div_divisor  = DIV_DEN_W'(irs_reg);
            end
            default: begin
                div_dividend = DIV_NUM_W'(rate_num_reg);
                div_divisor  = DIV_DEN_W'(WINDOW_LENGTH);
            end
        endcase
    end

    assign div_start = (state_reg == ST_LOAD);

    prse_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Sequencer and sample evaluation
    always_comb begin
        logic                  new_peak;
        logic                  beat;
        logic [RATE_W-1:0]     wb_new;
        logic [RATE_MUL_W-1:0] prod;
        logic [OXY_W-1:0]      oxy_val;

        state_next     = state_reg;
        valid_in_next  = valid_in_reg;
        ir_next        = ir_reg;
        red_next       = red_reg;
        irs_next       = irs_reg;
        peak_next      = peak_reg;
        thr_next       = thr_reg;
        wbeats_next    = wbeats_reg;
        wpos_next      = wpos_reg;
        since_next     = since_reg;
        total_next     = total_reg;
        rate_next      = rate_reg;
        interval_next  = interval_reg;
        oxy_next       = oxy_reg;
        beat_next      = beat_reg;
        need_thr_next  = need_thr_reg;
        need_oxy_next  = need_oxy_reg;
        need_rate_next = need_rate_reg;
        rate_num_next  = rate_num_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;

        new_peak = peak_reg < ir_reg;
        beat     = !new_peak && (ir_reg < thr_reg);
        wb_new   = (beat && (wbeats_reg != '1)) ? wbeats_reg + RATE_W'(1) : wbeats_reg;
        prod     = '0;
        oxy_val  = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    valid_in_next = s_tuser;
                    ir_next       = s_tdata[SAMPLE_W-1:0];
                    red_next      = s_tdata[2*SAMPLE_W-1:SAMPLE_W];
                    irs_next      = s_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
                    state_next    = ST_EVAL;
                end
            end
            ST_EVAL: begin
                need_thr_next  = 1'b0;
                need_oxy_next  = 1'b0;
                need_rate_next = 1'b0;
                if (!valid_in_reg) begin
                    // An invalid sample clears the whole tracking state.
                    peak_next     = '0;
                    thr_next      = '0;
                    wbeats_next   = '0;
                    wpos_next     = '0;
                    since_next    = '0;
                    total_next    = '0;
                    rate_next     = '0;
                    interval_next = '0;
                    oxy_next      = '0;
                    beat_next     = 1'b0;
                    state_next    = ST_DONE;
                end else begin
                    beat_next = beat;
                    if (new_peak) begin
                        peak_next     = ir_reg;
                        need_thr_next = 1'b1;
                        if (irs_reg == '0) begin
                            oxy_next = '0;
                        end else begin
                            need_oxy_next = 1'b1;
                        end
                    end else if (beat) begin
                        peak_next     = '0;
                        total_next    = (total_reg >= limit_cfg_reg) ? '0
                                                                     : total_reg + TOTAL_W'(1);
                        interval_next = INTERVAL_W'(since_reg) * INTERVAL_W'(MS_PER_SAMPLE);
                    end
                    if (beat) begin
                        since_next = SINCE_W'(1);
                    end else if (since_reg != '1) begin
                        since_next = since_reg + SINCE_W'(1);
                    end
                    wbeats_next = wb_new;

                    if (wpos_reg == POS_QUARTER) begin
                        prod      = RATE_MUL_W'(wb_new) * RATE_MUL_W'(MUL_QUARTER);
                        rate_next = sat_rate(DIV_NUM_W'(prod));
                        wpos_next = wpos_reg + POS_W'(1);
                    end else if (wpos_reg == POS_THIRD) begin
                        prod      = RATE_MUL_W'(wb_new) * RATE_MUL_W'(MUL_THIRD);
                        rate_next = sat_rate(DIV_NUM_W'(prod));
                        wpos_next = wpos_reg + POS_W'(1);
                    end else if (wpos_reg == POS_TWO_THIRDS) begin
                        prod      = RATE_MUL_W'(wb_new) * RATE_MUL_W'(MUL_TWO_THIRDS);
                        rate_next = sat_rate(DIV_NUM_W'(prod));
                        wpos_next = wpos_reg + POS_W'(1);
                    end else if (wpos_reg >= POS_W'(WINDOW_LENGTH)) begin
                        // Window end: the rate comes from the divider, the window restarts.
                        rate_num_next  = RATE_NUM_W'(wb_new) * RATE_NUM_W'(RATE_SCALE);
                        need_rate_next = 1'b1;
                        wbeats_next    = '0;
                        wpos_next      = '0;
                    end else begin
                        wpos_next = wpos_reg + POS_W'(1);
                    end

                    if (new_peak || (wpos_reg >= POS_W'(WINDOW_LENGTH)
                            && wpos_reg != POS_QUARTER && wpos_reg != POS_THIRD
                            && wpos_reg != POS_TWO_THIRDS)) begin
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_LOAD: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    case (cur_op)
                        OP_THRESHOLD: begin
                            thr_next      = div_quotient[SAMPLE_W-1:0];
                            need_thr_next = 1'b0;
                        end
                        OP_OXYGEN: begin
                            if (div_quotient >= DIV_NUM_W'(OXY_BASE)) begin
                                oxy_next = '0;
                            end else begin
                                oxy_val  = OXY_W'(OXY_BASE) - div_quotient[OXY_W-1:0];
                                oxy_next = (oxy_val > OXY_W'(OXY_MAX)) ? OXY_W'(OXY_MAX)
                                                                       : oxy_val;
                            end
                            need_oxy_next = 1'b0;
                        end
                        default: begin
                            rate_next      = sat_rate(div_quotient);
                            need_rate_next = 1'b0;
                        end
                    endcase
                    if (need_thr_next || need_oxy_next || need_rate_next) begin
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                // Hand the word over once the output register is free.
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, oxy_reg, total_reg, interval_reg, rate_reg};
                    m_tuser_next  = beat_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            peak_reg      <= '0;
            thr_reg       <= '0;
            wbeats_reg    <= '0;
            wpos_reg      <= '0;
            since_reg     <= '0;
            total_reg     <= '0;
            rate_reg      <= '0;
            interval_reg  <= '0;
            oxy_reg       <= '0;
            beat_reg      <= 1'b0;
            need_thr_reg  <= 1'b0;
            need_oxy_reg  <= 1'b0;
            need_rate_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            peak_reg      <= peak_next;
            thr_reg       <= thr_next;
            wbeats_reg    <= wbeats_next;
            wpos_reg      <= wpos_next;
            since_reg     <= since_next;
            total_reg     <= total_next;
            rate_reg      <= rate_next;
            interval_reg  <= interval_next;
            oxy_reg       <= oxy_next;
            beat_reg      <= beat_next;
            need_thr_reg  <= need_thr_next;
            need_oxy_reg  <= need_oxy_next;
            need_rate_reg <= need_rate_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        valid_in_reg <= valid_in_next;
        ir_reg       <= ir_next;
        red_reg      <= red_next;
        irs_reg      <= irs_next;
        rate_num_reg <= rate_num_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: rtl/prse_divider.sv
// Restoring divider that produces one quotient bit per clock cycle.
module prse_divider (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [prse_pkg::DIV_NUM_W-1:0] dividend,
    input  logic [prse_pkg::DIV_DEN_W-1:0] divisor,
    output logic                           done,
    output logic [prse_pkg::DIV_NUM_W-1:0] quotient
);
    import prse_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;

    logic [DIV_DEN_W:0]   rem_shift;
    logic [DIV_DEN_W:0]   rem_diff;
    logic                 fits;

    assign rem_shift = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign fits      = rem_shift >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_NUM_W);
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DIV_NUM_W-2:0], fits};
            rem_next = fits ? rem_diff[DIV_DEN_W-1:0] : rem_shift[DIV_DEN_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/prse_checker.sv
// Port-level checks of the pulse rate and SpO2 estimator, bound to the top level.
module prse_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [prse_pkg::APB_ADDR_W-1:0] paddr,
    input logic [prse_pkg::CFG_DATA_W-1:0] pwdata,
    input logic [prse_pkg::CFG_DATA_W-1:0] prdata,
    input logic                            pready,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [prse_pkg::S_TDATA_W-1:0]  s_tdata,
    input logic                            s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [prse_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                            m_tuser
);
    import prse_pkg::*;

    // A stalled result word keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // s_tready drops after a sample is taken, so the next sample waits for the current one.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("sample accepted on consecutive cycles");

    // The SpO2 estimate is clamped to 0..99.
    a_oxy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[54:48] <= 7'(OXY_MAX))
        else $error("oxygen estimate out of range");

    // The threshold divisor register is eight bits wide.
    a_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && (paddr[2] == REG_DIVISOR) |-> prdata[CFG_DATA_W-1:DIVISOR_W] == '0)
        else $error("divisor read back with upper bits set");

endmodule

bind pulse_rate_spo2_estimator prse_checker u_prse_checker (.*);
